[rtl/tts_pkg.sv]
// shared types and constants for the timed task scheduler table
`default_nettype none
package tts_pkg;
  localparam int unsigned TableDepth = 64;

  typedef enum logic [2:0] {
    FUNC_SCHEDULE = 3'd0,
    FUNC_ELAPSE   = 3'd1,
    FUNC_PICK     = 3'd2,
    FUNC_FINISH   = 3'd3,
    FUNC_CANCEL   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTREADY = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] module_tag;
    logic [31:0] match_id;
    logic [31:0] delay_us;
    logic [31:0] latency_class;
    logic [31:0] prio_level;
    logic        repeats;
    logic [31:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] head_id;
    logic [15:0] head_module;
    logic [31:0] wait_left;
    logic        still_running;
  } out_item_t;

  // sweep kinds issued by the controller
  typedef enum logic [2:0] {
    SW_FREE   = 3'd0,
    SW_ELAPSE = 3'd1,
    SW_HEAD   = 3'd2,
    SW_CHARGE = 3'd3,
    SW_CANCEL = 3'd4
  } sweep_t;

  typedef struct packed {
    logic   start;
    sweep_t kind;
    logic   head_fetch;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    logic fetch_done;
  } sts_t;
endpackage
`default_nettype wire

[rtl/tts_datapath.sv]
// table memory, sweep counter, head search and result assembly
`default_nettype none
module tts_datapath #(
  parameter int unsigned TABLE_DEPTH = tts_pkg::TableDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tts_pkg::in_item_t item,
  input  wire tts_pkg::cmd_t     cmd,
  output tts_pkg::sts_t          sts,
  output tts_pkg::out_item_t     result
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef struct packed {
    logic [15:0] mod;
    logic [31:0] id;
    logic [31:0] wt;
    logic [31:0] period;
    logic [63:0] key;
  } ent_t;

  ent_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] recur_r, canc_r;
  logic [31:0]      idc_r;

  logic             busy_r, busy_nxt;
  tts_pkg::sweep_t  kind_r;
  logic [AW:0]      cnt_r;          // read address counter
  logic             rd_v_r;
  logic [AW-1:0]    rd_a_r;
  ent_t             rd_d_r;

  logic             found_r;
  logic [AW-1:0]    hs_r;           // head or free slot
  logic [31:0]      hw_r;
  logic [63:0]      hk_r;
  logic             fetch_r, fetch_d_r, fetch_done_r;
  ent_t             hd_r;
  logic             done_r;

  logic [AW-1:0]    last;
  logic             better;
  logic [31:0]      sub;
  logic             match;
  logic             wr_en;
  logic [AW-1:0]    wr_a;
  ent_t             wr_d;

  assign last = AW'(TABLE_DEPTH - 1);
  assign better = !found_r || (rd_d_r.wt < hw_r) ||
                  ((rd_d_r.wt == hw_r) && (rd_d_r.key > hk_r));
  assign sub = (item.elapsed_us >= rd_d_r.wt) ? 32'd0 : rd_d_r.wt - item.elapsed_us;
  assign match = (rd_d_r.mod == item.module_tag) &&
                 ((item.match_id == 32'd0) || (rd_d_r.id == item.match_id));

  always_comb begin
    wr_en = 1'b0;
    wr_a  = rd_a_r;
    wr_d  = rd_d_r;
    if (rd_v_r && valid_r[rd_a_r]) begin
      if (kind_r == tts_pkg::SW_ELAPSE ||
          (kind_r == tts_pkg::SW_CHARGE && !(found_r && rd_a_r == hs_r))) begin
        wr_en = 1'b1;
        wr_d.wt = sub;
      end
    end
    if (cmd.commit && found_r) begin
      if (kind_r == tts_pkg::SW_FREE) begin
        wr_en = 1'b1;
        wr_a = hs_r;
        wr_d.mod = item.module_tag;
        wr_d.id = idc_r + 32'd1;
        wr_d.wt = item.delay_us;
        wr_d.period = item.delay_us;
        wr_d.key = {item.latency_class, item.prio_level};
      end else if (kind_r == tts_pkg::SW_CHARGE && recur_r[hs_r] && !canc_r[hs_r]) begin
        wr_en = 1'b1;
        wr_a = hs_r;
        wr_d = hd_r;
        wr_d.wt = hd_r.period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_a] <= wr_d;
    end
    rd_d_r <= mem[cnt_r[AW-1:0]];
    if (fetch_d_r) begin
      hd_r <= rd_d_r;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r[AW-1:0] == last) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      recur_r <= '0;
      canc_r <= '0;
      idc_r <= '0;
      busy_r <= 1'b0;
      rd_v_r <= 1'b0;
      done_r <= 1'b0;
      found_r <= 1'b0;
      fetch_r <= 1'b0;
      fetch_d_r <= 1'b0;
      fetch_done_r <= 1'b0;
      kind_r <= tts_pkg::SW_FREE;
      cnt_r <= '0;
      rd_a_r <= '0;
      hs_r <= '0;
      hw_r <= '0;
      hk_r <= '0;
      result <= '0;
    end else begin
      busy_r <= busy_nxt;
      rd_v_r <= busy_r;
      rd_a_r <= cnt_r[AW-1:0];
      done_r <= rd_v_r && !busy_r;
      fetch_r <= 1'b0;
      fetch_d_r <= fetch_r;
      fetch_done_r <= fetch_d_r;
      if (cmd.start) begin
        kind_r <= cmd.kind;
        cnt_r <= '0;
        if (cmd.kind != tts_pkg::SW_CHARGE) begin
          found_r <= 1'b0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.head_fetch) begin
        cnt_r <= {1'b0, hs_r};
        fetch_r <= 1'b1;
      end
      if (rd_v_r) begin
        case (kind_r)
          tts_pkg::SW_FREE: begin
            if (!valid_r[rd_a_r] && !found_r) begin
              found_r <= 1'b1;
              hs_r <= rd_a_r;
            end
          end
          tts_pkg::SW_HEAD: begin
            if (valid_r[rd_a_r] && better) begin
              found_r <= 1'b1;
              hs_r <= rd_a_r;
              hw_r <= rd_d_r.wt;
              hk_r <= rd_d_r.key;
            end
          end
          tts_pkg::SW_CANCEL: begin
            if (valid_r[rd_a_r] && match) begin
              if (rd_a_r == hs_r && hw_r == 32'd0) begin
                canc_r[rd_a_r] <= 1'b1;
                result.still_running <= 1'b1;
              end else begin
                valid_r[rd_a_r] <= 1'b0;
                recur_r[rd_a_r] <= 1'b0;
                canc_r[rd_a_r] <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.start && cmd.kind == tts_pkg::SW_FREE) begin
        result <= '0;
      end
      if (cmd.commit) begin
        case (kind_r)
          tts_pkg::SW_FREE: begin
            if (found_r) begin
              valid_r[hs_r] <= 1'b1;
              recur_r[hs_r] <= item.repeats;
              canc_r[hs_r] <= 1'b0;
              idc_r <= idc_r + 32'd1;
              result.head_id <= idc_r + 32'd1;
            end else begin
              result.status <= tts_pkg::ST_FULL;
            end
          end
          tts_pkg::SW_CHARGE: begin
            if (!recur_r[hs_r] || canc_r[hs_r]) begin
              valid_r[hs_r] <= 1'b0;
              recur_r[hs_r] <= 1'b0;
              canc_r[hs_r] <= 1'b0;
              result.wait_left <= '0;
            end else begin
              result.wait_left <= hd_r.period;
            end
          end
          default: begin
          end
        endcase
      end
      if (fetch_d_r) begin
        result.head_id <= rd_d_r.id;
        result.head_module <= rd_d_r.mod;
        result.wait_left <= rd_d_r.wt;
        result.status <= (rd_d_r.wt != 32'd0) ? tts_pkg::ST_NOTREADY : tts_pkg::ST_OK;
      end
      if (cmd.start && cmd.kind == tts_pkg::SW_ELAPSE) begin
        result <= '0;
      end
      if (cmd.start && cmd.kind == tts_pkg::SW_HEAD) begin
        result <= '0;
      end
      if (cmd.start && cmd.kind == tts_pkg::SW_CANCEL) begin
        result <= '0;
      end
      if (cmd.commit && kind_r == tts_pkg::SW_HEAD && !found_r) begin
        result <= '0;
        result.status <= tts_pkg::ST_EMPTY;
      end
    end
  end

  assign sts.done = done_r;
  assign sts.found = found_r;
  assign sts.fetch_done = fetch_done_r;
endmodule
`default_nettype wire

[rtl/tts_ctrl.sv]
// controller state machine sequencing the table sweeps
`default_nettype none
module tts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    func,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               capture,
  input  wire tts_pkg::sts_t sts,
  input  wire logic          not_ready,
  output tts_pkg::cmd_t      cmd
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FREE   = 9'b000000010,
    S_ELAPSE = 9'b000000100,
    S_HEAD   = 9'b000001000,
    S_FETCH  = 9'b000010000,
    S_CHARGE = 9'b000100000,
    S_CANCEL = 9'b001000000,
    S_COMMIT = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  func_r;

  assign in_stall = (state_r != S_IDLE);
  assign capture = in_valid && (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (func)
            tts_pkg::FUNC_SCHEDULE: begin
              cmd.kind = tts_pkg::SW_FREE;
              state_nxt = S_FREE;
            end
            tts_pkg::FUNC_ELAPSE: begin
              cmd.kind = tts_pkg::SW_ELAPSE;
              state_nxt = S_ELAPSE;
            end
            tts_pkg::FUNC_PICK, tts_pkg::FUNC_FINISH, tts_pkg::FUNC_CANCEL: begin
              cmd.kind = tts_pkg::SW_HEAD;
              state_nxt = S_HEAD;
            end
            default: begin
              cmd.kind = tts_pkg::SW_HEAD;
              cmd.start = 1'b0;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_FREE: if (sts.done) begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_ELAPSE: if (sts.done) state_nxt = S_OUT;
      S_HEAD: if (sts.done) begin
        if (!sts.found) begin
          cmd.kind = tts_pkg::SW_HEAD;
          cmd.commit = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.head_fetch = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: if (sts.fetch_done) begin
        if (func_r == tts_pkg::FUNC_FINISH && !not_ready) begin
          cmd.start = 1'b1;
          cmd.kind = tts_pkg::SW_CHARGE;
          state_nxt = S_CHARGE;
        end else if (func_r == tts_pkg::FUNC_CANCEL) begin
          cmd.start = 1'b1;
          cmd.kind = tts_pkg::SW_CANCEL;
          state_nxt = S_CANCEL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CHARGE: if (sts.done) begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_CANCEL: if (sts.done) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      func_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (capture) begin
        func_r <= func;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/timed_task_scheduler_table.sv]
// top level of the timed task scheduler table
// schedule and elapse take one sweep of the table; pick, finish and cancel sweep for the head
// and then fetch it (an empty table ends after the head sweep), and a finish whose head is ready
// or a cancel sweeps again, cancel adding a commit state; a sweep reads one entry per cycle
// throughput: one transaction at a time; the next is taken in the cycle after the result leaves
// reset: synchronous active low, clears valid bits, flags and the id counter
`default_nettype none
module timed_task_scheduler_table #(
  parameter int unsigned TABLE_DEPTH = tts_pkg::TableDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tts_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tts_pkg::out_item_t      out_item
);
  tts_pkg::in_item_t item_r;
  tts_pkg::cmd_t     cmd;
  tts_pkg::sts_t     sts;
  logic              capture;
  tts_pkg::out_item_t res;

  always_ff @(posedge clk) begin
    if (capture) begin
      item_r <= in_item;
    end
  end

  tts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .func(in_stall ? item_r.func : in_item.func),
    .out_valid(out_valid), .out_stall(out_stall), .capture(capture),
    .sts(sts), .not_ready(res.status == tts_pkg::ST_NOTREADY), .cmd(cmd)
  );

  tts_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .item(capture ? in_item : item_r),
    .cmd(cmd), .sts(sts), .result(res)
  );

  always_comb begin
    out_item = res;
    if (item_r.func > 3'(tts_pkg::FUNC_CANCEL)) begin
      out_item = '0;
    end
  end
endmodule
`default_nettype wire

[rtl/tts_checker.sv]
// port-level checker for the timed task scheduler table
`default_nettype none
module tts_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tts_pkg::out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transaction");
endmodule

bind timed_task_scheduler_table tts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire
